// ===== rtl/assert_macros.svh =====
// assertion helpers for the linked list engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion with active-low reset
`define SLLE_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define SLLE_ASSERT(lbl, prop, msg) `SLLE_ASSERT_IMPL(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/slle_pkg.sv =====
package slle_pkg;

    localparam int SLOTS_DEF = 8;

    typedef logic [1:0]         t_status;
    typedef logic signed [31:0] t_word;
    typedef logic [3:0]         t_pos;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_FULL   = 2'd1;
    localparam t_status ST_BADPOS = 2'd2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

endpackage

// ===== rtl/slle_ram.sv =====
module slle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/static_linked_list_engine_core.sv =====
// channel   signals                                      direction
// input     i_valid o_ready i_action i_position i_value  in
// output    o_valid i_ready o_status o_removed_value     out
//           o_element_count
//
// one word at a time; ready only while idle; reset empties the list at once
// insert: accept, scan for the lowest free slot, walk the links to the position,
//   write the new slot, and past position 1 also relink the slot before it, result
// delete: accept, walk the links, read the slot, unlink it, result; rejected words (full
//   or bad position) go straight to the result; link walk is bound by the registered
//   read port; a stalled result holds the engine in the result state of the next word
`include "assert_macros.svh"

module static_linked_list_engine_core #(
    parameter int SLOTS = slle_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_action,
    input  slle_pkg::t_pos    i_position,
    input  slle_pkg::t_word   i_value,
    output logic              o_valid,
    input  logic              i_ready,
    output slle_pkg::t_status o_status,
    output slle_pkg::t_word   o_removed_value,
    output slle_pkg::t_pos    o_element_count
);

    import slle_pkg::*;

    localparam int SW   = $clog2(SLOTS);
    localparam int LW   = $clog2(SLOTS + 1);
    localparam int CW   = LW;
    localparam int CMPW = ((CW > 4) ? CW : 4) + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_WALK   = 4'd2;
    localparam logic [3:0] S_WAIT   = 4'd3;
    localparam logic [3:0] S_INS1   = 4'd4;
    localparam logic [3:0] S_INS2   = 4'd5;
    localparam logic [3:0] S_DEL_RD = 4'd6;
    localparam logic [3:0] S_DEL_WR = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [SLOTS-1:0] r_used, n_used;
    logic [LW-1:0]    r_first, n_first;
    logic [CW-1:0]    r_count, n_count;
    logic             r_act, n_act;
    logic             r_pos1, n_pos1;
    logic [3:0]       r_left, n_left;
    logic [LW-1:0]    r_cur, n_cur;
    logic [LW-1:0]    r_prev, n_prev;
    logic [SW-1:0]    r_scan, n_scan;
    logic [SW-1:0]    r_free, n_free;
    t_word            r_val, n_val;
    t_status          r_status, n_status;
    t_word            r_removed, n_removed;
    logic             r_out_valid, n_out_valid;
    t_status          r_ostat, n_ostat;
    t_word            r_orem, n_orem;
    logic [3:0]       r_ocnt, n_ocnt;

    logic             w_link_we;
    logic [SW-1:0]    w_link_waddr;
    logic [LW-1:0]    w_link_wdata;
    logic [SW-1:0]    w_raddr;
    logic [LW-1:0]    w_link_rdata;
    logic             w_val_we;
    t_word            w_val_rdata;

    logic [CMPW-1:0]  w_pos_ext;
    logic [CMPW-1:0]  w_cnt_ext;
    logic [CW+3:0]    w_cnt_wide;

    assign w_pos_ext  = CMPW'(i_position);
    assign w_cnt_ext  = CMPW'(r_count);
    assign w_cnt_wide = {4'b0000, r_count};

    slle_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_link_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_link_rdata)
    );

    slle_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (r_free),
        .i_wdata (r_val),
        .i_raddr (w_raddr),
        .o_rdata (w_val_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_first     = r_first;
        n_count     = r_count;
        n_act       = r_act;
        n_pos1      = r_pos1;
        n_left      = r_left;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_scan      = r_scan;
        n_free      = r_free;
        n_val       = r_val;
        n_status    = r_status;
        n_removed   = r_removed;
        n_out_valid = r_out_valid;
        n_ostat     = r_ostat;
        n_orem      = r_orem;
        n_ocnt      = r_ocnt;
        w_link_we    = 1'b0;
        w_link_waddr = r_free;
        w_link_wdata = r_cur;
        w_raddr      = r_cur[SW-1:0];
        w_val_we     = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_act     = i_action;
                    n_val     = i_value;
                    n_pos1    = (i_position == 4'd1);
                    n_left    = i_position - 4'd1;
                    n_cur     = r_first;
                    n_scan    = '0;
                    n_status  = ST_OK;
                    n_removed = '0;
                    if (i_action == ACT_INSERT) begin
                        if (w_cnt_ext >= CMPW'(SLOTS)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else if (i_position == 4'd0 || w_pos_ext > w_cnt_ext + 1'b1) begin
                            n_status = ST_BADPOS;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (i_position == 4'd0 || w_pos_ext > w_cnt_ext) begin
                            n_status = ST_BADPOS;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (!r_used[r_scan]) begin
                    n_free  = r_scan;
                    n_state = S_WALK;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_WALK: begin
                if (r_left == 4'd0) begin
                    n_state = (r_act == ACT_DELETE) ? S_DEL_RD : S_INS1;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_prev  = r_cur;
                n_cur   = w_link_rdata;
                n_left  = r_left - 4'd1;
                n_state = S_WALK;
            end
            S_INS1: begin
                w_link_we    = 1'b1;
                w_link_waddr = r_free;
                w_link_wdata = r_cur;
                w_val_we     = 1'b1;
                n_used[r_free] = 1'b1;
                n_count = r_count + 1'b1;
                if (r_pos1) begin
                    n_first = LW'(r_free);
                    n_state = S_DONE;
                end else begin
                    n_state = S_INS2;
                end
            end
            S_INS2: begin
                w_link_we    = 1'b1;
                w_link_waddr = r_prev[SW-1:0];
                w_link_wdata = LW'(r_free);
                n_state      = S_DONE;
            end
            S_DEL_RD: begin
                n_state = S_DEL_WR;
            end
            S_DEL_WR: begin
                n_removed = w_val_rdata;
                if (r_pos1) begin
                    n_first = w_link_rdata;
                end else begin
                    w_link_we    = 1'b1;
                    w_link_waddr = r_prev[SW-1:0];
                    w_link_wdata = w_link_rdata;
                end
                n_used[r_cur[SW-1:0]] = 1'b0;
                n_count = r_count - 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_ostat     = r_status;
                    n_orem      = r_removed;
                    n_ocnt      = w_cnt_wide[3:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_first     <= LW'(SLOTS);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_first     <= n_first;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_act     <= n_act;
        r_pos1    <= n_pos1;
        r_left    <= n_left;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_scan    <= n_scan;
        r_free    <= n_free;
        r_val     <= n_val;
        r_status  <= n_status;
        r_removed <= n_removed;
        r_ostat   <= n_ostat;
        r_orem    <= n_orem;
        r_ocnt    <= n_ocnt;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_ostat;
    assign o_removed_value = r_orem;
    assign o_element_count = r_ocnt;

    `SLLE_ASSERT(a_cnt_used, $countones(r_used) == int'(r_count), "count differs from used slots")
    `SLLE_ASSERT(a_empty_head, (r_count == '0) |-> (r_first == LW'(SLOTS)), "empty list has a head")
    `SLLE_ASSERT(a_ins_count, (r_state == S_INS1) |=> (r_count == $past(r_count) + 1'b1), "insert count")
    `SLLE_ASSERT(a_accept_busy, (i_valid && o_ready) |=> (r_state != S_IDLE), "idle after accept")

endmodule
